// ===== hdl/mish_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_pkg
// Shared types and constants of the Q5.10 mish activation pipeline.
// ----------------------------------------------------------------------------
package mish_pkg;

  localparam int unsigned TERMS   = 24;   // series terms of e^-y
  localparam int unsigned SQUARES = 4;    // squarings that take e^-y to e^-16y
  localparam int unsigned QBITS   = 15;   // quotient bits, magnitude <= 16384
  localparam int unsigned NUM_W   = 33;
  localparam int unsigned DEN_W   = 34;
  localparam int unsigned DIV_W   = 49;

  localparam logic signed [15:0] LIMIT_POS = 16'sd16384;
  localparam logic signed [15:0] LIMIT_NEG = -16'sd16384;
  localparam logic [31:0] Q31_ONE  = 32'h8000_0000;
  localparam logic [63:0] Q31_HALF = 64'h0000_0000_4000_0000;

  // floor(2^32 / n), n = 1 .. TERMS
  localparam logic [32:0] RECIP [TERMS] = '{
    33'(64'h1_0000_0000 / 1),  33'(64'h1_0000_0000 / 2),
    33'(64'h1_0000_0000 / 3),  33'(64'h1_0000_0000 / 4),
    33'(64'h1_0000_0000 / 5),  33'(64'h1_0000_0000 / 6),
    33'(64'h1_0000_0000 / 7),  33'(64'h1_0000_0000 / 8),
    33'(64'h1_0000_0000 / 9),  33'(64'h1_0000_0000 / 10),
    33'(64'h1_0000_0000 / 11), 33'(64'h1_0000_0000 / 12),
    33'(64'h1_0000_0000 / 13), 33'(64'h1_0000_0000 / 14),
    33'(64'h1_0000_0000 / 15), 33'(64'h1_0000_0000 / 16),
    33'(64'h1_0000_0000 / 17), 33'(64'h1_0000_0000 / 18),
    33'(64'h1_0000_0000 / 19), 33'(64'h1_0000_0000 / 20),
    33'(64'h1_0000_0000 / 21), 33'(64'h1_0000_0000 / 22),
    33'(64'h1_0000_0000 / 23), 33'(64'h1_0000_0000 / 24)
  };

  typedef struct packed {
    logic [15:0] sample;   // raw input, two's complement
    logic [14:0] mag;      // |sample| when in range, else 0
  } meta_t;

  typedef struct packed {
    logic  valid;
    meta_t meta;
  } tag_t;

endpackage

// ===== hdl/mish_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_in_if / mish_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface mish_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mish_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] activation;
  modport source (output valid, output activation, input ready);
  modport sink   (input valid, input activation, output ready);
endinterface

// ===== hdl/mish_activation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_activation
// mish(x) = x * tanh(ln(1 + e^x)) on signed Q5.10 samples, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload                 Meaning
// in_i      in    sample [15:0] signed    Q5.10 input sample
// out_o     out   activation [15:0] sgn   Q5.10 mish of the sample
//
// One beat in and one beat out per cycle, sustained while out_o takes its beats.
// The stages run the 24-term series (multiply, reciprocal multiply,
// correct), five squarings, num/den and the product, the
// one-bit-per-stage divider and the output register, in that order.
// Reset clears all valid bits; payload registers are not reset.
// A stall on out_o freezes every stage together; in_i.ready drops with it.
// ----------------------------------------------------------------------------
module mish_activation import mish_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  mish_in_if.sink    in_i,
  mish_out_if.source out_o
);

  logic en;
  logic out_valid_q;
  logic signed [15:0] activation_q;

  // whole pipeline advances unless the output register holds an untaken beat
  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // ---- entry: magnitude, large inputs bypass the math ----
  tag_t        in_tag;
  logic [15:0] abs_s;
  logic        in_range;

  assign abs_s    = in_i.sample[15] ? 16'(-in_i.sample) : in_i.sample;
  assign in_range = in_i.sample inside {[LIMIT_NEG:LIMIT_POS]};

  always_comb begin
    in_tag.valid       = in_i.valid;
    in_tag.meta.sample = in_i.sample;
    in_tag.meta.mag    = in_range ? abs_s[14:0] : 15'd0;
  end

  // ---- e^-|x| and its square ----
  tag_t        exp_tag;
  logic [31:0] v;
  logic [31:0] w;

  mish_exp u_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (in_tag),
    .tag_o  (exp_tag),
    .v_o    (v),
    .w_o    (w)
  );

  // ---- tanh(softplus) as num/den ----
  // x >= 0: num = 1 + 2v,   den = num + 2w
  // x <  0: num = w + 2v,   den = num + 2
  logic [NUM_W-1:0] num_d;
  logic [DEN_W-1:0] den_d;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_q, den2_q, den3_q;
  logic [47:0]      prod_q;
  logic [DIV_W-1:0] dividend_q;
  tag_t             nd_tag_q, pr_tag_q, dv_tag_q;

  always_comb begin
    if (!exp_tag.meta.sample[15]) begin
      num_d = {1'b0, Q31_ONE} + {v, 1'b0};
      den_d = {1'b0, num_d} + {1'b0, w, 1'b0};
    end else begin
      num_d = {1'b0, w} + {v, 1'b0};
      den_d = {1'b0, num_d} + {1'b0, Q31_ONE, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_tag_q <= '0;
      pr_tag_q <= '0;
      dv_tag_q <= '0;
    end else if (en) begin
      nd_tag_q <= exp_tag;
      pr_tag_q <= nd_tag_q;
      dv_tag_q <= pr_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q      <= num_d;
      den_q      <= den_d;
      prod_q     <= {33'd0, nd_tag_q.meta.mag} * {15'd0, num_q};
      den2_q     <= den_q;
      // round half up on the magnitude
      dividend_q <= {1'b0, prod_q} + {{(DIV_W-DEN_W+1){1'b0}}, den2_q[DEN_W-1:1]};
      den3_q     <= den2_q;
    end
  end

  // ---- q = dividend / den ----
  tag_t             div_tag;
  logic [QBITS-1:0] quo;

  mish_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (dv_tag_q),
    .num_i  (dividend_q),
    .den_i  (den3_q),
    .tag_o  (div_tag),
    .quo_o  (quo)
  );

  // ---- sign, bypass cases, output register ----
  logic signed [15:0] fin_s;
  logic signed [15:0] result;

  assign fin_s = $signed(div_tag.meta.sample);

  always_comb begin
    if (fin_s > LIMIT_POS) begin
      result = fin_s;                       // mish(x) ~ x
    end else if (fin_s < LIMIT_NEG) begin
      result = '0;                          // vanishes below 1 LSB
    end else if (fin_s[15]) begin
      result = $signed(16'd0 - {1'b0, quo});
    end else begin
      result = $signed({1'b0, quo});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      activation_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.activation = activation_q;

  // ---- checks ----
  a_out_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.activation >= LIMIT_NEG)
    else $error("activation below -16.0");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(div_tag) && $stable(quo))
    else $error("divider moved during stall");

  a_exp_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_tag.valid |-> (v <= Q31_ONE) && (w <= v))
    else $error("exponential out of range");

endmodule

// ===== hdl/mish_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_exp
// Pipelined e^(-a/1024) in Q1.31: series, four squarings, then one more
// squaring for w = v^2.
// ----------------------------------------------------------------------------
module mish_exp import mish_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  tag_t        tag_i,
  output tag_t        tag_o,
  output logic [31:0] v_o,
  output logic [31:0] w_o
);

  logic [31:0]        term_w [TERMS+1];
  logic signed [33:0] sum_w  [TERMS+1];
  tag_t               tag_w  [TERMS+1];

  assign term_w[0] = Q31_ONE;
  assign sum_w[0]  = $signed({2'b00, Q31_ONE});
  assign tag_w[0]  = tag_i;

  for (genvar g = 0; g < TERMS; g++) begin : g_term
    localparam logic [4:0] N = 5'(g + 1);

    logic [46:0]        prod_q;
    logic signed [33:0] sum1_q, sum2_q, sum3_q;
    tag_t               tag1_q, tag2_q, tag3_q;
    logic [31:0]        pval_q, est_q, term_q;
    logic [64:0]        rmul;
    logic [36:0]        est_n;
    logic [36:0]        rem;
    logic [31:0]        term_d;

    // reciprocal estimate is exact or one low
    assign rmul   = {33'd0, prod_q[45:14]} * {32'd0, RECIP[g]};
    assign est_n  = {5'd0, est_q} * {32'd0, N};
    assign rem    = {5'd0, pval_q} - est_n;
    assign term_d = (rem >= {32'd0, N}) ? est_q + 32'd1 : est_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag1_q <= '0;
        tag2_q <= '0;
        tag3_q <= '0;
      end else if (en_i) begin
        tag1_q <= tag_w[g];
        tag2_q <= tag1_q;
        tag3_q <= tag2_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q <= {15'd0, term_w[g]} * {32'd0, tag_w[g].meta.mag};
        sum1_q <= sum_w[g];
        pval_q <= prod_q[45:14];
        est_q  <= rmul[63:32];
        sum2_q <= sum1_q;
        term_q <= term_d;
        sum3_q <= (N[0]) ? sum2_q - $signed({2'b00, term_d})
                         : sum2_q + $signed({2'b00, term_d});
      end
    end

    assign term_w[g+1] = term_q;
    assign sum_w[g+1]  = sum3_q;
    assign tag_w[g+1]  = tag3_q;
  end

  // squarings: SQUARES for v, one more for w
  logic [31:0] sv_w  [SQUARES+2];
  logic [31:0] sp_w  [SQUARES+2];
  tag_t        stag_w[SQUARES+2];

  assign sv_w[0]   = sum_w[TERMS][33] ? 32'd0 : sum_w[TERMS][31:0];
  assign sp_w[0]   = '0;
  assign stag_w[0] = tag_w[TERMS];

  for (genvar i = 0; i <= SQUARES; i++) begin : g_sq
    logic [63:0] sq_q;
    logic [31:0] vin_q, vout_q, vprev_q;
    logic [63:0] rnd;
    tag_t        taga_q, tagb_q;

    assign rnd = sq_q + Q31_HALF;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        taga_q <= '0;
        tagb_q <= '0;
      end else if (en_i) begin
        taga_q <= stag_w[i];
        tagb_q <= taga_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q    <= {32'd0, sv_w[i]} * {32'd0, sv_w[i]};
        vin_q   <= sv_w[i];
        vout_q  <= rnd[62:31];
        vprev_q <= vin_q;
      end
    end

    assign sv_w[i+1]   = vout_q;
    assign sp_w[i+1]   = vprev_q;
    assign stag_w[i+1] = tagb_q;
  end

  assign tag_o = stag_w[SQUARES+1];
  assign v_o   = sp_w[SQUARES+1];
  assign w_o   = sv_w[SQUARES+1];

endmodule

// ===== hdl/mish_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_div
// Restoring divider, one quotient bit per stage, fully pipelined.
// ----------------------------------------------------------------------------
module mish_div import mish_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  tag_t             tag_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output tag_t             tag_o,
  output logic [QBITS-1:0] quo_o
);

  logic [DIV_W-1:0] rem_w [QBITS+1];
  logic [DEN_W-1:0] den_w [QBITS+1];
  logic [QBITS-1:0] quo_w [QBITS+1];
  tag_t             tag_w [QBITS+1];

  assign rem_w[0] = num_i;
  assign den_w[0] = den_i;
  assign quo_w[0] = '0;
  assign tag_w[0] = tag_i;

  for (genvar k = 0; k < QBITS; k++) begin : g_bit
    localparam int unsigned B = QBITS - 1 - k;

    logic [DIV_W-1:0] trial;
    logic             ge;
    logic [QBITS-1:0] quo_d;
    logic [DIV_W-1:0] rem_q;
    logic [DEN_W-1:0] den_q;
    logic [QBITS-1:0] quo_q;
    tag_t             tag_q;

    assign trial = {{(DIV_W-DEN_W){1'b0}}, den_w[k]} << B;
    assign ge    = rem_w[k] >= trial;

    always_comb begin
      quo_d    = quo_w[k];
      quo_d[B] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q <= '0;
      end else if (en_i) begin
        tag_q <= tag_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= ge ? rem_w[k] - trial : rem_w[k];
        den_q <= den_w[k];
        quo_q <= quo_d;
      end
    end

    assign rem_w[k+1] = rem_q;
    assign den_w[k+1] = den_q;
    assign quo_w[k+1] = quo_q;
    assign tag_w[k+1] = tag_q;
  end

  assign tag_o = tag_w[QBITS];
  assign quo_o = quo_w[QBITS];

endmodule

// ===== bench/mish_activation_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mish_activation_test
// Streams Q5.10 samples through the mish pipeline under random backpressure
// and source gaps, and checks every result beat against a bit-exact predictor.
// ----------------------------------------------------------------------------
module mish_activation_test import mish_pkg::*; ();

  localparam int unsigned LATENCY = 101;

  logic clk_i;
  logic rst_ni;

  mish_in_if  in_ch ();
  mish_out_if out_ch ();

  mish_activation dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Mish results still owed by the pipeline, oldest first.
  logic signed [15:0] pending_mish[$];
  int unsigned        mismatch_cnt;
  bit                 sink_stall_en;   // random backpressure on the output
  bit                 src_gap_en;      // random gaps on the input
  int unsigned        hold_cycles;     // receiver hold-off, in cycles

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // e^(-a/1024) in Q1.31: truncated series of e^(-a/16384), squared four times.
  function automatic logic [63:0] exp_neg_q31(input logic [31:0] a);
    logic signed [63:0] sum;
    logic [63:0]        term;
    logic [63:0]        v;
    sum  = 64'sh8000_0000;
    term = 64'h8000_0000;
    for (int n = 1; n <= TERMS; n++) begin
      term = (term * 64'(a)) / (64'd16384 * 64'(n));
      if (term == 0) break;
      if (n % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    v = sum;
    for (int i = 0; i < SQUARES; i++) v = (v * v + Q31_HALF) >> 31;
    return v;
  endfunction

  function automatic logic signed [15:0] mish_q510(input logic signed [15:0] s);
    logic [31:0]        a;
    logic [63:0]        v, w, num, den;
    logic [127:0]       q;
    logic signed [63:0] r;
    if (s > LIMIT_POS) begin
      r = s;
    end else if (s < LIMIT_NEG) begin
      r = 0;
    end else begin
      a = (s < 0) ? 32'(-int'(s)) : 32'(int'(s));
      v = exp_neg_q31(a);
      w = (v * v + Q31_HALF) >> 31;
      if (s >= 0) begin
        num = 64'(Q31_ONE) + 2 * v;
        den = num + 2 * w;
      end else begin
        num = w + 2 * v;
        den = num + 2 * 64'(Q31_ONE);
      end
      q = (128'(a) * 128'(num) + 128'(den / 2)) / 128'(den);
      r = (s < 0) ? -$signed(64'(q)) : $signed(64'(q));
    end
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Offer one sample, optionally after a random gap; returns once accepted.
  task automatic send_sample(input logic signed [15:0] s);
    if (src_gap_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    pending_mish.push_back(mish_q510(s));
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    go_idle();
    while (pending_mish.size() != 0) @(posedge clk_i);
  endtask

  // Field extremes, range limits and zero.
  task automatic test_directed();
    logic signed [15:0] edge_vals[$];
    edge_vals = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1,
                  16'sd16384, -16'sd16384, 16'sd16385, -16'sd16385,
                  16'sd16383, -16'sd16383, 16'sd1024, -16'sd1024,
                  16'sd2048, -16'sd2048, -16'sd1229, 16'sd512, -16'sd512,
                  16'sh5555, 16'shAAAA};
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    drain();
  endtask

  // Mostly the computed range, some beyond the limits, full 16-bit noise.
  task automatic test_random(input int unsigned count);
    logic signed [15:0] s;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       s = 16'($urandom());
        1:       s = 16'($urandom_range(0, 2047) - 1024);
        default: s = 16'($urandom_range(0, 32768) - 16384);
      endcase
      send_sample(s);
    end
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall its input.
  task automatic test_backpressure();
    hold_cycles = 3 * LATENCY;
    fork
      test_random(LATENCY + 60);
    join
    drain();
  endtask

  // Random gaps and stalls; the closing part runs with neither.
  task automatic test_stream();
    sink_stall_en = 1'b1;
    src_gap_en    = 1'b1;
    test_random(360);
    drain();           // sender pauses until every result is back
    test_random(60);
    sink_stall_en = 1'b0;
    src_gap_en    = 1'b0;
    test_random(100);
    drain();
  endtask

  // Sink side: random bursts of stall, plus the long hold-off when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else if (sink_stall_en && out_ch.ready && $urandom_range(0, 5) == 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles  <= $urandom_range(0, 6);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Checker: every accepted result beat against the oldest prediction.
  always @(posedge clk_i) begin
    logic signed [15:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_mish.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: activation=%0d", out_ch.activation);
      end else begin
        want = pending_mish.pop_front();
        if (out_ch.activation !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("activation mismatch: expected %0d, got %0d",
                     want, out_ch.activation);
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    mismatch_cnt  = 0;
    sink_stall_en = 1'b0;
    src_gap_en    = 1'b0;
    hold_cycles   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_stream();
    repeat (LATENCY + 20) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_mish.size() == 0) begin
      $display("PASS mish_activation");
    end else begin
      $display("FAIL mish_activation");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAIL mish_activation");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mish_pkg.sv
hdl/mish_if.sv
hdl/mish_exp.sv
hdl/mish_div.sv
hdl/mish_activation.sv
bench/mish_activation_test.sv
